### rtl/jtl_pkg.sv
// Shared types and constants for the JSON token lexer.
package jtl_pkg;

	localparam int BYTE_W  = 8;
	localparam int TOKEN_W = 4;
	localparam int CAP_W   = 16;
	localparam int OUT_CNT_W = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

	typedef enum logic [TOKEN_W-1:0] {
		TK_NONE   = 4'd0,
		TK_ERR    = 4'd1,
		TK_STR    = 4'd2,
		TK_TRUE   = 4'd3,
		TK_FALSE  = 4'd4,
		TK_NULL   = 4'd5,
		TK_AOPEN  = 4'd6,
		TK_ACLOSE = 4'd7,
		TK_OOPEN  = 4'd8,
		TK_OCLOSE = 4'd9,
		TK_COLON  = 4'd10,
		TK_COMMA  = 4'd11
	} token_t;

	typedef enum logic [12:0] {
		ST_START = 13'b0000000000001,
		ST_F     = 13'b0000000000010,
		ST_FA    = 13'b0000000000100,
		ST_FAL   = 13'b0000000001000,
		ST_FALS  = 13'b0000000010000,
		ST_N     = 13'b0000000100000,
		ST_NU    = 13'b0000001000000,
		ST_NUL   = 13'b0000010000000,
		ST_T     = 13'b0000100000000,
		ST_TR    = 13'b0001000000000,
		ST_TRU   = 13'b0010000000000,
		ST_STR   = 13'b0100000000000,
		ST_ESC   = 13'b1000000000000
	} lex_state_t;

	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_VT     = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [TOKEN_W-1:0]   token;
		logic                 char_valid;
		logic [BYTE_W-1:0]    content_char;
		logic [OUT_CNT_W-1:0] content_count;
	} out_item_t;

endpackage

### rtl/jtl_stream_if.sv
// Valid/ready channel carrying one payload per beat.
interface jtl_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/jtl_step.sv
// Next-state and result logic of the lexer for one input byte.
module jtl_step #(
	parameter int COUNT_WIDTH = 16
) (
	input  jtl_pkg::lex_state_t       state,
	input  logic [COUNT_WIDTH-1:0]    count,
	input  logic [jtl_pkg::CAP_W-1:0] capacity,
	input  logic [jtl_pkg::BYTE_W-1:0] in_byte,
	output jtl_pkg::lex_state_t       next_state,
	output logic [COUNT_WIDTH-1:0]    next_count,
	output jtl_pkg::out_item_t        result
);
	import jtl_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;

	token_t            tok;
	logic              chv;
	logic [BYTE_W-1:0] chr;
	logic [BYTE_W-1:0] esc_char;
	logic              can_store;

	// A character fits when the count is below both the capacity and its own maximum.
	assign can_store = (CMP_W'(count) < CMP_W'(capacity)) && !(&count);

	always_comb begin
		unique case (in_byte)
			"b":     esc_char = CH_BS;
			"f":     esc_char = CH_FF;
			"n":     esc_char = CH_LF;
			"r":     esc_char = CH_CR;
			"t":     esc_char = CH_TAB;
			"v":     esc_char = CH_VT;
			"0":     esc_char = CH_NUL;
			default: esc_char = in_byte;
		endcase
	end

	always_comb begin
		next_state = state;
		next_count = count;
		tok        = TK_NONE;
		chv        = 1'b0;
		chr        = '0;
		unique case (state)
			ST_F: begin
				next_state = ST_FA;
				tok = (in_byte == "a") ? TK_NONE : TK_ERR;
			end
			ST_FA: begin
				next_state = ST_FAL;
				tok = (in_byte == "l") ? TK_NONE : TK_ERR;
			end
			ST_FAL: begin
				next_state = ST_FALS;
				tok = (in_byte == "s") ? TK_NONE : TK_ERR;
			end
			ST_FALS: begin
				next_state = ST_START;
				tok = (in_byte == "e") ? TK_FALSE : TK_ERR;
			end
			ST_N: begin
				next_state = ST_NU;
				tok = (in_byte == "u") ? TK_NONE : TK_ERR;
			end
			ST_NU: begin
				next_state = ST_NUL;
				tok = (in_byte == "l") ? TK_NONE : TK_ERR;
			end
			ST_NUL: begin
				next_state = ST_START;
				tok = (in_byte == "l") ? TK_NULL : TK_ERR;
			end
			ST_T: begin
				next_state = ST_TR;
				tok = (in_byte == "r") ? TK_NONE : TK_ERR;
			end
			ST_TR: begin
				next_state = ST_TRU;
				tok = (in_byte == "u") ? TK_NONE : TK_ERR;
			end
			ST_TRU: begin
				next_state = ST_START;
				tok = (in_byte == "e") ? TK_TRUE : TK_ERR;
			end
			ST_STR: begin
				if (in_byte == CH_QUOTE) begin
					next_state = ST_START;
					tok = TK_STR;
				end else if (in_byte == CH_BSLASH) begin
					next_state = ST_ESC;
				end else if (in_byte >= CH_SPACE && in_byte <= CH_TILDE && can_store) begin
					next_count = count + 1'b1;
					chv = 1'b1;
					chr = in_byte;
				end else begin
					tok = TK_ERR;
				end
			end
			ST_ESC: begin
				next_state = ST_STR;
				if (can_store) begin
					next_count = count + 1'b1;
					chv = 1'b1;
					chr = esc_char;
				end else begin
					tok = TK_ERR;
				end
			end
			default: begin
				// Start state; the count clears on every byte here, ready for a new token.
				next_state = ST_START;
				next_count = '0;
				unique case (in_byte)
					"f":      next_state = ST_F;
					"n":      next_state = ST_N;
					"t":      next_state = ST_T;
					CH_QUOTE: next_state = ST_STR;
					"[":      tok = TK_AOPEN;
					"]":      tok = TK_ACLOSE;
					"{":      tok = TK_OOPEN;
					"}":      tok = TK_OCLOSE;
					":":      tok = TK_COLON;
					",":      tok = TK_COMMA;
					CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: tok = TK_NONE;
					default:  tok = TK_ERR;
				endcase
			end
		endcase
	end

	assign result.token         = tok;
	assign result.char_valid    = chv;
	assign result.content_char  = chr;
	assign result.content_count = OUT_CNT_W'(next_count);

endmodule

### rtl/json_token_lexer.sv
// JSON token lexer: byte stream in, one token/character result per byte out.
//
// Channels: in_ch carries one text byte per beat, out_ch one result per
// input byte (token code, stored string character with its valid flag and
// the running character count). cfg writes content_capacity, the largest
// number of characters one string may store; it is always ready and should
// only be written while no byte is in flight.
// Path: a byte accepted on in_ch lands in the input register, and the lexer
// step then loads its result into the result register, which drives
// out_ch.
// Throughput: one byte per cycle while out_ch takes results; the whole lexer
// update for a byte is one pass through the step logic, so bytes can stream.
// Stall: while out_ch is not taken, the result holds, the input register
// holds its byte and in_ch drops ready once both are full; nothing is lost.
// Reset: arst_n clears the pipeline valids, returns the lexer to its start
// state with a zero count, and sets content_capacity to 65535.
module json_token_lexer #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	jtl_stream_if.sink   in_ch,
	jtl_stream_if.source out_ch,
	jtl_stream_if.sink   cfg
);
	import jtl_pkg::*;

	logic                   valid_s1;
	logic [BYTE_W-1:0]      byte_s1;
	logic                   out_valid_q;
	out_item_t              out_data_q;
	lex_state_t             state_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [CAP_W-1:0]       capacity_q;

	lex_state_t             state_d;
	logic [COUNT_WIDTH-1:0] count_d;
	out_item_t              result;
	logic                   out_free;
	logic                   advance;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign advance     = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;
	assign cfg.ready   = 1'b1;

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	jtl_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.state     (state_q),
		.count     (count_q),
		.capacity  (capacity_q),
		.in_byte   (byte_s1),
		.next_state(state_d),
		.next_count(count_d),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= ST_START;
			count_q     <= '0;
			capacity_q  <= CAP_RESET;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				state_q <= state_d;
				count_q <= count_d;
			end
			if (cfg.valid) begin
				capacity_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data.in_byte;
		end
		if (advance) begin
			out_data_q <= result;
		end
	end

endmodule
